[rtl/cover_sensor_event_qualifier_top_assert.svh]
`ifndef COVER_SENSOR_EVENT_QUALIFIER_TOP_ASSERT_SVH
`define COVER_SENSOR_EVENT_QUALIFIER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSEVQ_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CSEVQ_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/csevq_pkg.sv]
package csevq_pkg;

  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned CFG_BITS   = 16;
  localparam int unsigned IDX_BITS   = 2;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_DEFAULT = 16'd50;
  localparam logic [CFG_BITS-1:0] HOLD_OFF_DEFAULT = 16'd3000;

  localparam logic ST_OPEN   = 1'b0;
  localparam logic ST_CLOSED = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SUSPEND = 2'd1,
    OP_RESUME  = 2'd2,
    OP_INIT    = 2'd3
  } csevq_op_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_OPENED = 2'd1,
    EV_CLOSED = 2'd2
  } csevq_event_e;

  typedef enum logic [IDX_BITS-1:0] {
    REG_BOARD_SUPPORTED = 2'd0,
    REG_CLOSE_DEBOUNCE  = 2'd1,
    REG_HOLD_OFF        = 2'd2
  } csevq_reg_e;

  typedef struct packed {
    logic                board_supported;
    logic [CFG_BITS-1:0] close_debounce_ms;
    logic [CFG_BITS-1:0] hold_off_ms;
  } csevq_cfg_t;

  typedef struct packed {
    csevq_event_e event_res;
    logic         reported_closed;
    logic         wake_enabled;
    logic         edge_rising;
    logic         button_reset_enabled;
    logic         woke_by_sensor;
  } csevq_result_t;

  // saturates a delay setting into the timer width
  function automatic logic [TIMER_BITS-1:0] timer_load(logic [CFG_BITS-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > 32'(TIMER_MAX)) begin
      return TIMER_MAX;
    end
    return TIMER_BITS'(wide);
  endfunction

endpackage

[rtl/csevq_cfg.sv]
module csevq_cfg
  import csevq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [IDX_BITS-1:0] wr_index_i,
  input  logic [CFG_BITS-1:0] wr_data_i,
  output csevq_cfg_t          cfg_o
);

  csevq_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        REG_BOARD_SUPPORTED: cfg_d.board_supported   = wr_data_i[0];
        REG_CLOSE_DEBOUNCE:  cfg_d.close_debounce_ms = wr_data_i;
        REG_HOLD_OFF:        cfg_d.hold_off_ms       = wr_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.board_supported   <= 1'b1;
      cfg_q.close_debounce_ms <= DEBOUNCE_DEFAULT;
      cfg_q.hold_off_ms       <= HOLD_OFF_DEFAULT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/csevq_core.sv]
`include "cover_sensor_event_qualifier_top_assert.svh"

module csevq_core
  import csevq_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  csevq_op_e     op_i,
  input  logic          level_i,
  input  csevq_cfg_t    cfg_i,
  output csevq_result_t result_o
);

  typedef struct packed {
    logic                  reported_state;
    logic                  last_level;
    logic                  recent_open;
    logic [TIMER_BITS-1:0] close_timer;
    logic                  close_pending;
    logic [TIMER_BITS-1:0] open_timer;
    logic                  open_pending;
    logic                  wake_on;
    logic                  trigger_rising;
    logic                  button_reset_on;
    logic                  event_seen;
    logic                  resume_by_sensor;
  } state_t;

  state_t       state_q, state_d;
  csevq_event_e ev;
  logic         close_new, open_new, bs;

  assign bs = cfg_i.board_supported;

  always_comb begin
    state_d   = state_q;
    ev        = EV_NONE;
    close_new = 1'b0;
    open_new  = 1'b0;
    unique case (op_i)
      OP_TICK: begin
        if ((level_i != state_q.last_level) && bs) begin
          if (level_i) begin
            state_d.button_reset_on = 1'b0;
            state_d.trigger_rising  = 1'b1;
            state_d.wake_on         = 1'b1;
            state_d.open_pending    = 1'b0;
            state_d.open_timer      = '0;
            state_d.close_timer     = timer_load(state_q.recent_open ?
                                                 cfg_i.hold_off_ms : cfg_i.close_debounce_ms);
            state_d.close_pending   = 1'b1;
            close_new               = 1'b1;
          end else begin
            state_d.close_pending = 1'b0;
            state_d.close_timer   = '0;
            if (state_q.reported_state != ST_OPEN) begin
              state_d.reported_state = ST_OPEN;
              ev                     = EV_OPENED;
            end
            state_d.recent_open     = 1'b1;
            state_d.open_timer      = timer_load(cfg_i.hold_off_ms);
            state_d.open_pending    = 1'b1;
            open_new                = 1'b1;
            state_d.trigger_rising  = 1'b0;
            state_d.wake_on         = 1'b0;
            state_d.button_reset_on = 1'b1;
          end
          state_d.event_seen = 1'b1;
        end
        state_d.last_level = level_i;

        // timers started in this tick do not count yet
        if (state_d.close_pending && !close_new) begin
          if (state_d.close_timer != '0) begin
            state_d.close_timer = state_d.close_timer - TIMER_BITS'(1);
          end
          if (state_d.close_timer == '0) begin
            state_d.close_pending = 1'b0;
            if (level_i && (state_d.reported_state == ST_OPEN)) begin
              state_d.reported_state = ST_CLOSED;
              ev                     = EV_CLOSED;
            end
          end
        end
        if (state_d.open_pending && !open_new) begin
          if (state_d.open_timer != '0) begin
            state_d.open_timer = state_d.open_timer - TIMER_BITS'(1);
          end
          if (state_d.open_timer == '0) begin
            state_d.open_pending = 1'b0;
            if (!level_i) begin
              state_d.recent_open = 1'b0;
            end
          end
        end
      end
      OP_SUSPEND: begin
        if (!level_i) begin
          state_d.trigger_rising = 1'b0;
          if (bs) begin
            state_d.wake_on = 1'b1;
          end
        end
        state_d.resume_by_sensor = 1'b0;
        state_d.event_seen       = 1'b0;
      end
      OP_RESUME: begin
        if (state_q.event_seen) begin
          state_d.resume_by_sensor = 1'b1;
          state_d.event_seen       = 1'b0;
        end else if (!level_i) begin
          state_d.trigger_rising = 1'b0;
          if (bs) begin
            state_d.wake_on = 1'b0;
          end
        end
      end
      OP_INIT: begin
        if (level_i) begin
          state_d.button_reset_on = 1'b0;
          state_d.trigger_rising  = 1'b1;
          if (bs) begin
            state_d.wake_on = 1'b1;
          end
          state_d.reported_state = ST_CLOSED;
        end else begin
          state_d.trigger_rising = 1'b0;
          if (bs) begin
            state_d.wake_on = 1'b0;
          end
          state_d.reported_state = ST_OPEN;
        end
        state_d.last_level = level_i;
      end
      default: state_d = state_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{button_reset_on: 1'b1, default: '0};
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  assign result_o.event_res            = ev;
  assign result_o.reported_closed      = state_d.reported_state;
  assign result_o.wake_enabled         = state_d.wake_on;
  assign result_o.edge_rising          = state_d.trigger_rising;
  assign result_o.button_reset_enabled = state_d.button_reset_on;
  assign result_o.woke_by_sensor       = state_d.resume_by_sensor;

  `CSEVQ_ASSERT_IMPL(a_pending_excl, 1'b1, !(state_q.close_pending && state_q.open_pending), "close and open delays both pending")
  `CSEVQ_ASSERT_NEXT(a_close_done, step_i && (ev == EV_CLOSED), !state_q.close_pending && state_q.reported_state == ST_CLOSED, "close report left delay pending")
  `CSEVQ_ASSERT_IMPL(a_event_tick, ev != EV_NONE, op_i == OP_TICK, "event raised outside a tick")

endmodule

[rtl/cover_sensor_event_qualifier_top.sv]
// a request is held in the input register once accepted; its result is loaded
// into the result register when the input stage advances
// throughput: one request per cycle unless the output stalls; the state update
// is a single pass of logic; reset (asynchronous, active low) clears both stages,
// the sensor state and restores the registers to board enabled, 50 and 3000 ticks
`include "cover_sensor_event_qualifier_top_assert.svh"

module cover_sensor_event_qualifier_top
  import csevq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [0] cover_closed, rest zero
  input  logic [1:0]          s_axis_tuser,   // [1:0] opcode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [1:0] event_res, [2] reported_closed,
                                              // [3] wake_enabled, [4] edge_rising,
                                              // [5] button_reset_enabled,
                                              // [6] woke_by_sensor, [7] zero
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  logic          in_valid_q;
  csevq_op_e     in_op_q;
  logic          in_level_q;
  logic          out_valid_q;
  logic [7:0]    out_data_q;
  logic          advance;
  csevq_cfg_t    cfg;
  csevq_result_t result;

  assign cfg_ready_o = 1'b1;

  csevq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // the input stage moves on when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q    <= csevq_op_e'(s_axis_tuser);
      in_level_q <= s_axis_tdata[0];
    end
  end

  csevq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .op_i     (in_op_q),
    .level_i  (in_level_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {1'b0, result.woke_by_sensor, result.button_reset_enabled,
                     result.edge_rising, result.wake_enabled, result.reported_closed,
                     result.event_res};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `CSEVQ_ASSERT_NEXT(a_advance_loads, advance, out_valid_q, "result register missed a request")
  `CSEVQ_ASSERT_IMPL(a_closed_report, out_valid_q && (out_data_q[1:0] == EV_CLOSED), out_data_q[2], "closed report without closed state")
  `CSEVQ_ASSERT_IMPL(a_opened_report, out_valid_q && (out_data_q[1:0] == EV_OPENED), !out_data_q[2], "opened report with closed state")

endmodule

[tb/cover_sensor_event_qualifier_top_test.sv]
module cover_sensor_event_qualifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csevq_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [0] cover_closed, rest zero
  logic [1:0]          s_axis_tuser = '0;   // [1:0] opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // [1:0] event_res, [2] reported_closed,
                                            // [3] wake_enabled, [4] edge_rising,
                                            // [5] button_reset_enabled,
                                            // [6] woke_by_sensor, [7] zero
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_BITS-1:0] cfg_data_i = '0;

  cover_sensor_event_qualifier_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("cover_sensor_event_qualifier_top_test NOT OK");
    $finish;
  end

  typedef struct packed {
    csevq_op_e     op;
    logic          lvl;
    logic          typed;
    csevq_result_t want;
  } dir_row_t;

  // shadow of the configuration registers
  logic                  board_en   = 1'b1;
  logic [CFG_BITS-1:0]   deb_ticks  = DEBOUNCE_DEFAULT;
  logic [CFG_BITS-1:0]   hold_ticks = HOLD_OFF_DEFAULT;

  // qualifier state as the block should hold it
  logic                  rep_state     = ST_OPEN;
  logic                  prev_level    = 1'b0;
  logic                  opened_lately = 1'b0;
  logic [TIMER_BITS-1:0] close_cnt     = '0;
  logic                  close_armed   = 1'b0;
  logic [TIMER_BITS-1:0] open_cnt      = '0;
  logic                  open_armed    = 1'b0;
  logic                  wake_q        = 1'b0;
  logic                  rise_q        = 1'b0;
  logic                  btn_rst_q     = 1'b1;
  logic                  seen_evt      = 1'b0;
  logic                  woke_q        = 1'b0;

  csevq_result_t status_q[$];
  int            n_bad = 0;
  int            src_idle_pct = 0;
  int            snk_idle_pct = 0;
  logic          hold_req = 1'b0;
  logic          sensor_lvl = 1'b0;
  int            run_left = 0;
  dir_row_t      dir_rows[$];

  function automatic logic [TIMER_BITS-1:0] sat_timer(logic [CFG_BITS-1:0] v);
    return (32'(v) > 32'(TIMER_MAX)) ? TIMER_MAX : TIMER_BITS'(v);
  endfunction

  // applies one request to the shadow state and returns the status it should produce
  function automatic csevq_result_t qualify_request(csevq_op_e op, logic lvl);
    csevq_result_t r;
    logic          close_fresh;
    logic          open_fresh;
    r = '0;
    r.event_res = EV_NONE;
    close_fresh = 1'b0;
    open_fresh  = 1'b0;
    case (op)
      OP_TICK: begin
        if (lvl != prev_level && board_en) begin
          if (lvl) begin
            btn_rst_q   = 1'b0;
            rise_q      = 1'b1;
            wake_q      = 1'b1;
            open_armed  = 1'b0;
            open_cnt    = '0;
            close_cnt   = sat_timer(opened_lately ? hold_ticks : deb_ticks);
            close_armed = 1'b1;
            close_fresh = 1'b1;
          end else begin
            close_armed = 1'b0;
            close_cnt   = '0;
            if (rep_state != ST_OPEN) begin
              rep_state   = ST_OPEN;
              r.event_res = EV_OPENED;
            end
            opened_lately = 1'b1;
            open_cnt      = sat_timer(hold_ticks);
            open_armed    = 1'b1;
            open_fresh    = 1'b1;
            rise_q        = 1'b0;
            wake_q        = 1'b0;
            btn_rst_q     = 1'b1;
          end
          seen_evt = 1'b1;
        end
        prev_level = lvl;
        if (close_armed && !close_fresh) begin
          if (close_cnt != 0) close_cnt = close_cnt - 1'b1;
          if (close_cnt == 0) begin
            close_armed = 1'b0;
            if (lvl && rep_state == ST_OPEN) begin
              rep_state   = ST_CLOSED;
              r.event_res = EV_CLOSED;
            end
          end
        end
        if (open_armed && !open_fresh) begin
          if (open_cnt != 0) open_cnt = open_cnt - 1'b1;
          if (open_cnt == 0) begin
            open_armed = 1'b0;
            if (!lvl) opened_lately = 1'b0;
          end
        end
      end
      OP_SUSPEND: begin
        if (!lvl) begin
          rise_q = 1'b0;
          if (board_en) wake_q = 1'b1;
        end
        woke_q   = 1'b0;
        seen_evt = 1'b0;
      end
      OP_RESUME: begin
        if (seen_evt) begin
          woke_q   = 1'b1;
          seen_evt = 1'b0;
        end else if (!lvl) begin
          rise_q = 1'b0;
          if (board_en) wake_q = 1'b0;
        end
      end
      default: begin
        if (lvl) begin
          btn_rst_q = 1'b0;
          rise_q    = 1'b1;
          if (board_en) wake_q = 1'b1;
          rep_state = ST_CLOSED;
        end else begin
          rise_q = 1'b0;
          if (board_en) wake_q = 1'b0;
          rep_state = ST_OPEN;
        end
        prev_level = lvl;
      end
    endcase
    r.reported_closed      = (rep_state == ST_CLOSED);
    r.wake_enabled         = wake_q;
    r.edge_rising          = rise_q;
    r.button_reset_enabled = btn_rst_q;
    r.woke_by_sensor       = woke_q;
    return r;
  endfunction

  function automatic dir_row_t row(csevq_op_e op, logic lvl, logic typed,
                                   csevq_event_e ev, logic rep, logic wake,
                                   logic edg, logic btn, logic woke);
    dir_row_t d;
    d.op                        = op;
    d.lvl                       = lvl;
    d.typed                     = typed;
    d.want.event_res            = ev;
    d.want.reported_closed      = rep;
    d.want.wake_enabled         = wake;
    d.want.edge_rising          = edg;
    d.want.button_reset_enabled = btn;
    d.want.woke_by_sensor       = woke;
    return d;
  endfunction

  task automatic send_req(csevq_op_e op, logic lvl, logic typed, csevq_result_t want);
    csevq_result_t model;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model = qualify_request(op, lvl);
    status_q.push_back(typed ? want : model);
  endtask

  task automatic write_reg(csevq_reg_e idx, logic [CFG_BITS-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_BOARD_SUPPORTED: board_en   = val[0];
      REG_CLOSE_DEBOUNCE:  deb_ticks  = val;
      default:             hold_ticks = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_and_configure(logic board, logic [CFG_BITS-1:0] deb,
                                     logic [CFG_BITS-1:0] hold);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(REG_BOARD_SUPPORTED, {15'd0, board});
    write_reg(REG_CLOSE_DEBOUNCE, deb);
    write_reg(REG_HOLD_OFF, hold);
  endtask

  // mostly ticks with runs of a steady level, plus suspend, resume and init
  task automatic random_traffic(int n_items);
    csevq_op_e op;
    logic      lvl;
    int        pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 84) begin
        op = OP_TICK;
        if (run_left == 0) begin
          sensor_lvl = ~sensor_lvl;
          run_left   = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
        end
        run_left--;
        lvl = sensor_lvl;
      end else if (pick < 96) begin
        op = (pick < 90) ? OP_SUSPEND : OP_RESUME;
        // sensor may move while the system sleeps
        if ($urandom_range(3) == 0) sensor_lvl = ~sensor_lvl;
        lvl = sensor_lvl;
      end else begin
        op         = OP_INIT;
        sensor_lvl = 1'($urandom_range(1));
        lvl        = sensor_lvl;
      end
      send_req(op, lvl, 1'b0, '0);
    end
  endtask

  // result side: random back-pressure, one long hold-off on request
  initial begin : result_side
    int            hold_cnt;
    logic          hold_taken;
    csevq_result_t want;
    csevq_result_t got;
    hold_cnt   = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_cnt   = 80;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.event_res            = csevq_event_e'(m_axis_tdata[1:0]);
        got.reported_closed      = m_axis_tdata[2];
        got.wake_enabled         = m_axis_tdata[3];
        got.edge_rising          = m_axis_tdata[4];
        got.button_reset_enabled = m_axis_tdata[5];
        got.woke_by_sensor       = m_axis_tdata[6];
        if (status_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected status %h with no request pending", m_axis_tdata);
        end else begin
          want = status_q.pop_front();
          if (got.event_res !== want.event_res ||
              got.reported_closed !== want.reported_closed ||
              got.wake_enabled !== want.wake_enabled ||
              got.edge_rising !== want.edge_rising ||
              got.button_reset_enabled !== want.button_reset_enabled ||
              got.woke_by_sensor !== want.woke_by_sensor ||
              m_axis_tdata[7] !== 1'b0) begin
            n_bad++;
            if (n_bad <= 10)
              $display("status mismatch at %0t: exp ev=%0d rep=%0b wake=%0b rise=%0b btn=%0b woke=%0b, got tdata=%b",
                       $realtime, want.event_res, want.reported_closed, want.wake_enabled,
                       want.edge_rising, want.button_reset_enabled, want.woke_by_sensor,
                       m_axis_tdata);
          end
        end
      end
    end
  end

  initial begin : request_side
    // short delays so the debounce and hold-off paths finish inside the table
    dir_rows.push_back(row(OP_TICK,    1'b0, 1'b1, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b1, 1'b1, EV_NONE,   1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b1, 1'b1, EV_CLOSED, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b0, 1'b1, EV_OPENED, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    // close right after an open waits the hold-off
    dir_rows.push_back(row(OP_TICK,    1'b1, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b0, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b0, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b0, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    // bounce cancels a pending close
    dir_rows.push_back(row(OP_TICK,    1'b1, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b0, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b1, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b1, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b1, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    // level changes while suspended show up on the next tick
    dir_rows.push_back(row(OP_SUSPEND, 1'b1, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_RESUME,  1'b0, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b0, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_SUSPEND, 1'b0, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b1, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_RESUME,  1'b1, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_INIT,    1'b0, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_INIT,    1'b1, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_TICK,    1'b1, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_SUSPEND, 1'b1, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(row(OP_RESUME,  1'b0, 1'b0, EV_NONE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 30;
    snk_idle_pct = 57;
    drain_and_configure(1'b1, 16'd1, 16'd2);
    foreach (dir_rows[i]) send_req(dir_rows[i].op, dir_rows[i].lvl, dir_rows[i].typed,
                                   dir_rows[i].want);
    sensor_lvl = prev_level;

    drain_and_configure(1'b1, 16'd3, 16'd8);
    random_traffic(250);

    src_idle_pct = 57;
    snk_idle_pct = 30;
    drain_and_configure(1'b0, 16'd0, 16'd0);
    random_traffic(200);
    drain_and_configure(1'b1, 16'd0, 16'hFFFF);
    random_traffic(250);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    drain_and_configure(1'b1, 16'hFFFF, 16'd5);
    hold_req = 1'b1;
    random_traffic(250);
    drain_and_configure(1'b1, 16'd2, 16'd1);
    random_traffic(200);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (n_bad == 0 && status_q.size() == 0) begin
      $display("cover_sensor_event_qualifier_top_test OK");
    end else begin
      $display("cover_sensor_event_qualifier_top_test NOT OK");
    end
    $finish;
  end

endmodule
